### rtl/aeg_pkg.sv
// shared types, constants and microcode program of the adsr envelope generator
`default_nettype none

package aeg_pkg;

	localparam int DAC_BITS  = 12;
	localparam int FRAC_BITS = 16;
	localparam int LVL_W     = FRAC_BITS + 1;
	localparam int TIME_W    = 32;
	localparam int DUR_W     = 16;
	localparam int EL_W      = 8;
	localparam int PH_W      = 3;
	localparam int OP_W      = 2;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = DUR_W + LVL_W;
	localparam int DIV_ITERS = LVL_W;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);
	localparam int UPC_W     = 5;

	localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(1) << FRAC_BITS;

	localparam logic [DUR_W-1:0] ATTACK_RST  = DUR_W'(10);
	localparam logic [DUR_W-1:0] DECAY_RST   = DUR_W'(100);
	localparam logic [LVL_W-1:0] SUSTAIN_RST = LVL_W'(32768);
	localparam logic [DUR_W-1:0] RELEASE_RST = DUR_W'(200);

	localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
	localparam logic [OP_W-1:0] OP_GATE_ON  = 2'd1;
	localparam logic [OP_W-1:0] OP_GATE_OFF = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

	typedef enum logic [PH_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		U_NOP, U_ADDT, U_MUL, U_DIVINIT, U_DIVSTEP, U_WR_ATT, U_WR_DEC,
		U_WR_REL, U_WR_SUS, U_NEXTPH, U_GATE_ON, U_GATE_OFF, U_EMIT
	} uop_t;

	typedef enum logic [1:0] {SEL_ATT, SEL_DEC, SEL_REL, SEL_GATE} sel_t;

	typedef enum logic [3:0] {
		JC_NEXT, JC_ALWAYS, JC_OP_GON, JC_OP_GOFF, JC_OP_BAD, JC_PH_ATT,
		JC_PH_DEC, JC_PH_REL, JC_PH_IDLE, JC_T_GT_A, JC_T_GT_D, JC_T_GT_R,
		JC_DIV_BUSY, JC_OUT_BUSY
	} jc_t;

	typedef struct packed {
		uop_t             uop;
		sel_t             sel;
		jc_t              jc;
		logic [UPC_W-1:0] target;
		logic             last;
	} ucw_t;

	typedef struct packed {
		logic op_gon;
		logic op_goff;
		logic op_bad;
		logic ph_att;
		logic ph_dec;
		logic ph_rel;
		logic ph_idle;
		logic t_gt_a;
		logic t_gt_d;
		logic t_gt_r;
		logic div_busy;
		logic out_busy;
	} flags_t;

	// microcode entry points
	localparam logic [UPC_W-1:0] A_ATT  = 5'd9;
	localparam logic [UPC_W-1:0] A_DIVA = 5'd12;
	localparam logic [UPC_W-1:0] A_DEC  = 5'd14;
	localparam logic [UPC_W-1:0] A_DIVD = 5'd17;
	localparam logic [UPC_W-1:0] A_REL  = 5'd19;
	localparam logic [UPC_W-1:0] A_DIVR = 5'd22;
	localparam logic [UPC_W-1:0] A_NEXT = 5'd24;
	localparam logic [UPC_W-1:0] A_EMIT = 5'd25;
	localparam logic [UPC_W-1:0] A_END  = 5'd26;
	localparam logic [UPC_W-1:0] A_GON  = 5'd27;
	localparam logic [UPC_W-1:0] A_GOFF = 5'd29;

	function automatic ucw_t mk(input uop_t u, input sel_t s, input jc_t j,
			input logic [UPC_W-1:0] t, input logic l);
		ucw_t w;
		w.uop = u;
		w.sel = s;
		w.jc = j;
		w.target = t;
		w.last = l;
		return w;
	endfunction

	function automatic ucw_t ucode(input logic [UPC_W-1:0] addr);
		ucw_t w;
		unique case (addr)
			5'd0:  w = mk(U_NOP, SEL_ATT, JC_OP_GON, A_GON, 1'b0);
			5'd1:  w = mk(U_NOP, SEL_ATT, JC_OP_GOFF, A_GOFF, 1'b0);
			5'd2:  w = mk(U_NOP, SEL_ATT, JC_OP_BAD, A_END, 1'b0);
			5'd3:  w = mk(U_ADDT, SEL_ATT, JC_NEXT, '0, 1'b0);
			5'd4:  w = mk(U_NOP, SEL_ATT, JC_PH_ATT, A_ATT, 1'b0);
			5'd5:  w = mk(U_NOP, SEL_ATT, JC_PH_DEC, A_DEC, 1'b0);
			5'd6:  w = mk(U_NOP, SEL_ATT, JC_PH_REL, A_REL, 1'b0);
			5'd7:  w = mk(U_NOP, SEL_ATT, JC_PH_IDLE, A_EMIT, 1'b0);
			5'd8:  w = mk(U_WR_SUS, SEL_ATT, JC_ALWAYS, A_EMIT, 1'b0);
			// attack
			5'd9:  w = mk(U_NOP, SEL_ATT, JC_T_GT_A, A_NEXT, 1'b0);
			5'd10: w = mk(U_MUL, SEL_ATT, JC_NEXT, '0, 1'b0);
			5'd11: w = mk(U_DIVINIT, SEL_ATT, JC_NEXT, '0, 1'b0);
			5'd12: w = mk(U_DIVSTEP, SEL_ATT, JC_DIV_BUSY, A_DIVA, 1'b0);
			5'd13: w = mk(U_WR_ATT, SEL_ATT, JC_ALWAYS, A_EMIT, 1'b0);
			// decay
			5'd14: w = mk(U_NOP, SEL_DEC, JC_T_GT_D, A_NEXT, 1'b0);
			5'd15: w = mk(U_MUL, SEL_DEC, JC_NEXT, '0, 1'b0);
			5'd16: w = mk(U_DIVINIT, SEL_DEC, JC_NEXT, '0, 1'b0);
			5'd17: w = mk(U_DIVSTEP, SEL_DEC, JC_DIV_BUSY, A_DIVD, 1'b0);
			5'd18: w = mk(U_WR_DEC, SEL_DEC, JC_ALWAYS, A_EMIT, 1'b0);
			// release
			5'd19: w = mk(U_NOP, SEL_REL, JC_T_GT_R, A_NEXT, 1'b0);
			5'd20: w = mk(U_MUL, SEL_REL, JC_NEXT, '0, 1'b0);
			5'd21: w = mk(U_DIVINIT, SEL_REL, JC_NEXT, '0, 1'b0);
			5'd22: w = mk(U_DIVSTEP, SEL_REL, JC_DIV_BUSY, A_DIVR, 1'b0);
			5'd23: w = mk(U_WR_REL, SEL_REL, JC_ALWAYS, A_EMIT, 1'b0);
			// segment end, result, done
			5'd24: w = mk(U_NEXTPH, SEL_ATT, JC_NEXT, '0, 1'b0);
			5'd25: w = mk(U_EMIT, SEL_ATT, JC_OUT_BUSY, A_EMIT, 1'b0);
			5'd26: w = mk(U_NOP, SEL_ATT, JC_NEXT, '0, 1'b1);
			// gate on / gate off
			5'd27: w = mk(U_MUL, SEL_GATE, JC_NEXT, '0, 1'b0);
			5'd28: w = mk(U_GATE_ON, SEL_GATE, JC_ALWAYS, A_END, 1'b0);
			5'd29: w = mk(U_GATE_OFF, SEL_ATT, JC_ALWAYS, A_END, 1'b0);
			default: w = mk(U_NOP, SEL_ATT, JC_NEXT, '0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/aeg_divider.sv
// restoring divider, one quotient bit per cycle while step is high
`default_nettype none

module aeg_divider
	import aeg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              step,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [DUR_W-1:0]  divisor,
	output logic [LVL_W-1:0]       quotient,
	output logic                   busy
);

	logic [DUR_W-1:0]     rem_q;
	logic [LVL_W-1:0]     quo_q;
	logic [DUR_W-1:0]     div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DUR_W:0]       trial;
	logic [DUR_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[LVL_W-1]};
	assign ge = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};
	assign quotient = quo_q;
	// more steps remain after the current one
	assign busy = cnt_q > DIV_CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_ITERS);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	// quotient fits 17 bits, so the top dividend bits start below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1 -: DUR_W];
			quo_q <= dividend[LVL_W-1:0];
			div_q <= divisor;
		end else if (step) begin
			rem_q <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
			quo_q <= {quo_q[LVL_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

### rtl/aeg_datapath.sv
// envelope datapath: settings, envelope state, shared multiplier, divider, result register
`default_nettype none

module aeg_datapath
	import aeg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_load,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [EL_W-1:0]      elapsed_ms,
	input  wire ucw_t                 ucw,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [DAC_BITS-1:0]       dac_code,
	output logic [PH_W-1:0]           phase_out,
	output flags_t                    flags
);

	logic [DUR_W-1:0]    attack_q;
	logic [DUR_W-1:0]    decay_q;
	logic [LVL_W-1:0]    sustain_q;
	logic [DUR_W-1:0]    release_q;
	phase_t              phase_q;
	logic [TIME_W-1:0]   time_q;
	logic [LVL_W-1:0]    level_q;
	logic [LVL_W-1:0]    rstart_q;
	logic                was_idle_q;
	logic [OP_W-1:0]     op_q;
	logic [EL_W-1:0]     el_q;
	logic [PROD_W-1:0]   prod_q;
	logic                out_valid_q;
	logic [DAC_BITS-1:0] dac_q;
	logic [PH_W-1:0]     phout_q;

	logic [LVL_W-1:0]          sus_c;
	logic [LVL_W-1:0]          mul_a;
	logic [LVL_W-1:0]          mul_b;
	logic [2*LVL_W-1:0]        mul_full;
	logic [DUR_W-1:0]          div_raw;
	logic [DUR_W-1:0]          div_nz;
	logic [LVL_W-1:0]          quotient;
	logic                      div_busy;
	logic [TIME_W:0]           time_sum;
	logic [LVL_W+DAC_BITS-1:0] dac_ext;
	logic [DAC_BITS:0]         dac_raw;
	logic [DAC_BITS-1:0]       dac_sat;
	logic                      out_busy;
	logic                      emit;

	assign sus_c = (sustain_q > FULL_SCALE) ? FULL_SCALE : sustain_q;

	always_comb begin
		unique case (ucw.sel)
			SEL_ATT: begin
				mul_a = {1'b0, time_q[DUR_W-1:0]};
				mul_b = FULL_SCALE;
				div_raw = attack_q;
			end
			SEL_DEC: begin
				mul_a = FULL_SCALE - sus_c;
				mul_b = {1'b0, time_q[DUR_W-1:0]};
				div_raw = decay_q;
			end
			SEL_REL: begin
				// time is at most release_ms here
				mul_a = rstart_q;
				mul_b = {1'b0, release_q - time_q[DUR_W-1:0]};
				div_raw = release_q;
			end
			SEL_GATE: begin
				mul_a = level_q;
				mul_b = {1'b0, attack_q};
				div_raw = attack_q;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign div_nz = (div_raw == '0) ? DUR_W'(1) : div_raw;

	aeg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ucw.uop == U_DIVINIT),
		.step     (ucw.uop == U_DIVSTEP),
		.dividend (prod_q),
		.divisor  (div_nz),
		.quotient (quotient),
		.busy     (div_busy)
	);

	assign time_sum = {1'b0, time_q} + (TIME_W+1)'(el_q);

	assign dac_ext = {level_q, {DAC_BITS{1'b0}}};
	assign dac_raw = dac_ext[DAC_BITS+FRAC_BITS:FRAC_BITS];
	assign dac_sat = dac_raw[DAC_BITS] ? '1 : dac_raw[DAC_BITS-1:0];

	assign out_busy = out_valid_q && out_stall;
	assign emit = (ucw.uop == U_EMIT) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RST;
			decay_q <= DECAY_RST;
			sustain_q <= SUSTAIN_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTACK:  attack_q <= cfg_data[DUR_W-1:0];
				CFG_DECAY:   decay_q <= cfg_data[DUR_W-1:0];
				CFG_SUSTAIN: sustain_q <= cfg_data[LVL_W-1:0];
				CFG_RELEASE: release_q <= cfg_data[DUR_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			time_q <= '0;
			level_q <= '0;
			rstart_q <= '0;
			was_idle_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (ucw.uop)
				U_ADDT: begin
					time_q <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
					was_idle_q <= (phase_q == PH_IDLE);
				end
				U_WR_ATT: level_q <= quotient;
				U_WR_DEC: level_q <= FULL_SCALE - quotient;
				U_WR_REL: level_q <= quotient;
				U_WR_SUS: level_q <= sus_c;
				U_NEXTPH: begin
					time_q <= '0;
					unique case (phase_q)
						PH_ATTACK:  phase_q <= PH_DECAY;
						PH_DECAY:   phase_q <= PH_SUSTAIN;
						PH_RELEASE: phase_q <= PH_IDLE;
						default:    phase_q <= phase_q;
					endcase
				end
				U_GATE_ON: begin
					// retrigger: resume attack where it would reach the held level
					time_q <= (phase_q != PH_IDLE) ? TIME_W'(prod_q[PROD_W-1:FRAC_BITS]) : '0;
					phase_q <= PH_ATTACK;
				end
				U_GATE_OFF: begin
					phase_q <= PH_RELEASE;
					time_q <= '0;
					rstart_q <= level_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			op_q <= op;
			el_q <= elapsed_ms;
		end
		if (ucw.uop == U_MUL) begin
			prod_q <= mul_full[PROD_W-1:0];
		end
		if (emit) begin
			dac_q <= was_idle_q ? '0 : dac_sat;
			phout_q <= phase_q;
		end
	end

	assign out_valid = out_valid_q;
	assign dac_code = dac_q;
	assign phase_out = phout_q;

	always_comb begin
		flags.op_gon = (op_q == OP_GATE_ON);
		flags.op_goff = (op_q == OP_GATE_OFF);
		flags.op_bad = (op_q == OP_UNUSED);
		flags.ph_att = (phase_q == PH_ATTACK);
		flags.ph_dec = (phase_q == PH_DECAY);
		flags.ph_rel = (phase_q == PH_RELEASE);
		flags.ph_idle = (phase_q == PH_IDLE);
		flags.t_gt_a = time_q > TIME_W'(attack_q);
		flags.t_gt_d = time_q > TIME_W'(decay_q);
		flags.t_gt_r = time_q > TIME_W'(release_q);
		flags.div_busy = div_busy;
		flags.out_busy = out_busy;
	end

endmodule

`default_nettype wire

### rtl/aeg_sequencer.sv
// microcode sequencer: step counter, program table read and branch selection
`default_nettype none

module aeg_sequencer
	import aeg_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire flags_t flags,
	output ucw_t        ucw,
	output logic        busy
);

	logic             busy_q;
	logic [UPC_W-1:0] upc_q;
	ucw_t             word;
	logic             take;

	assign word = ucode(upc_q);

	always_comb begin
		unique case (word.jc)
			JC_NEXT:     take = 1'b0;
			JC_ALWAYS:   take = 1'b1;
			JC_OP_GON:   take = flags.op_gon;
			JC_OP_GOFF:  take = flags.op_goff;
			JC_OP_BAD:   take = flags.op_bad;
			JC_PH_ATT:   take = flags.ph_att;
			JC_PH_DEC:   take = flags.ph_dec;
			JC_PH_REL:   take = flags.ph_rel;
			JC_PH_IDLE:  take = flags.ph_idle;
			JC_T_GT_A:   take = flags.t_gt_a;
			JC_T_GT_D:   take = flags.t_gt_d;
			JC_T_GT_R:   take = flags.t_gt_r;
			JC_DIV_BUSY: take = flags.div_busy;
			JC_OUT_BUSY: take = flags.out_busy;
			default:     take = 1'b0;
		endcase
	end

	// datapath sees no-ops while idle
	assign ucw = busy_q ? word : mk(U_NOP, SEL_ATT, JC_NEXT, '0, 1'b0);
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				upc_q <= '0;
			end
		end else if (word.last) begin
			busy_q <= 1'b0;
			upc_q <= '0;
		end else begin
			upc_q <= take ? word.target : upc_q + UPC_W'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/adsr_envelope_generator_unit.sv
// top level of the linear adsr envelope generator
//
//  channel  direction  handshake              word
//  cfg      in         cfg_we                 cfg_index, cfg_data
//  in       in         in_valid / in_stall    op, elapsed_ms
//  out      out        out_valid / out_stall  dac_code, phase_out
//
// one word at a time; in_stall is high from accept until the program ends
// gate on and gate off words never divide; a tick can divide only in attack, decay or release
// a tick that divides runs the 17-step divider
// a stalled result holds the program at its output step; no clearing pass
// after reset: envelope state and settings load their defaults at once
`default_nettype none

module adsr_envelope_generator_unit
	import aeg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [EL_W-1:0]      elapsed_ms,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [DAC_BITS-1:0]       dac_code,
	output logic [PH_W-1:0]           phase_out
);

	ucw_t   ucw;
	flags_t flags;
	logic   busy;
	logic   accept;

	assign in_stall = busy;
	assign accept = in_valid && !busy;

	aeg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.flags  (flags),
		.ucw    (ucw),
		.busy   (busy)
	);

	aeg_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_load    (accept),
		.op         (op),
		.elapsed_ms (elapsed_ms),
		.ucw        (ucw),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.dac_code   (dac_code),
		.phase_out  (phase_out),
		.flags      (flags)
	);

endmodule

`default_nettype wire

### rtl/aeg_checker.sv
// port-level checks for the adsr envelope generator, bound to the top level
`default_nettype none

module aeg_checker
	import aeg_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [DAC_BITS-1:0]  dac_code,
	input wire logic [PH_W-1:0]      phase_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dac_code) && $stable(phase_out))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a word");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_stall)
		else $error("result appeared with no word in progress");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("extra result produced while idle");

endmodule

bind adsr_envelope_generator_unit aeg_checker u_chk (.*);

`default_nettype wire

### verif/tb_top.sv
// testbench of the linear adsr envelope generator: directed and random words checked against a predictor
`timescale 1ns / 1ps

module tb_top;
	import aeg_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [DAC_BITS-1:0] dac;
		phase_t              ph;
	} env_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      op = OP_TICK;
	logic [EL_W-1:0]      elapsed_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [DAC_BITS-1:0]  dac_code;
	logic [PH_W-1:0]      phase_out;

	// predictor state and settings, loaded with the reset values
	phase_t           env_phase = PH_IDLE;
	logic [TIME_W-1:0] env_time = '0;
	logic [LVL_W-1:0] env_level = '0;
	logic [LVL_W-1:0] env_rel_start = '0;
	logic [DUR_W-1:0] att_ms = ATTACK_RST;
	logic [DUR_W-1:0] dec_ms = DECAY_RST;
	logic [LVL_W-1:0] sus_lvl = SUSTAIN_RST;
	logic [DUR_W-1:0] rel_ms = RELEASE_RST;

	env_word_t pending_codes[$];
	int        fails = 0;
	int        cycles = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        stall_hold = 0;

	adsr_envelope_generator_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dac_code   (dac_code),
		.phase_out  (phase_out)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] ms_divisor(input logic [DUR_W-1:0] d);
		return (d == '0) ? 64'd1 : 64'(d);
	endfunction

	// next state and expected output for one accepted word
	function automatic void advance_envelope(input logic [OP_W-1:0] o, input logic [EL_W-1:0] e);
		logic [TIME_W:0]   sum;
		logic [63:0]       t;
		logic [63:0]       num;
		logic [LVL_W-1:0]  susc;
		logic [LVL_W-5:0]  code;
		logic              was_idle;
		env_word_t         w;
		case (o)
			OP_GATE_ON: begin
				if (env_phase != PH_IDLE)
					env_time = TIME_W'((64'(env_level) * 64'(att_ms)) >> FRAC_BITS);
				else
					env_time = '0;
				env_phase = PH_ATTACK;
			end
			OP_GATE_OFF: begin
				env_phase = PH_RELEASE;
				env_time = '0;
				env_rel_start = env_level;
			end
			OP_TICK: begin
				sum = {1'b0, env_time} + (TIME_W + 1)'(e);
				env_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
				t = 64'(env_time);
				was_idle = (env_phase == PH_IDLE);
				susc = (sus_lvl > FULL_SCALE) ? FULL_SCALE : sus_lvl;
				case (env_phase)
					PH_ATTACK: begin
						if (t > 64'(att_ms)) begin
							env_phase = PH_DECAY;
							env_time = '0;
						end else begin
							env_level = LVL_W'((t << FRAC_BITS) / ms_divisor(att_ms));
						end
					end
					PH_DECAY: begin
						if (t > 64'(dec_ms)) begin
							env_phase = PH_SUSTAIN;
							env_time = '0;
						end else begin
							num = 64'(FULL_SCALE - susc) * t;
							env_level = FULL_SCALE - LVL_W'(num / ms_divisor(dec_ms));
						end
					end
					PH_SUSTAIN: env_level = susc;
					PH_RELEASE: begin
						if (t > 64'(rel_ms)) begin
							env_phase = PH_IDLE;
							env_time = '0;
						end else begin
							num = 64'(env_rel_start) * (64'(rel_ms) - t);
							env_level = LVL_W'(num / ms_divisor(rel_ms));
						end
					end
					default: ;
				endcase
				// full scale maps one past the top code
				code = env_level[LVL_W-1:FRAC_BITS-DAC_BITS];
				if (was_idle)
					w.dac = '0;
				else if (code[DAC_BITS])
					w.dac = '1;
				else
					w.dac = code[DAC_BITS-1:0];
				w.ph = env_phase;
				pending_codes.push_back(w);
			end
			default: ;
		endcase
	endfunction

	function automatic void note_failure(input string msg);
		fails++;
		if (fails <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endfunction

	// result checker
	always @(posedge clk) begin
		env_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0) begin
				note_failure($sformatf("unexpected word dac_code %0d phase_out %0d",
					dac_code, phase_out));
			end else begin
				e = pending_codes.pop_front();
				if (dac_code !== e.dac)
					note_failure($sformatf("dac_code expected %0d got %0d", e.dac, dac_code));
				if (phase_out !== e.ph)
					note_failure($sformatf("phase_out expected %0d got %0d", e.ph, phase_out));
			end
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_word(input logic [OP_W-1:0] o, input logic [EL_W-1:0] e);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		elapsed_ms <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_envelope(o, e);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		// a trailing gate word may still be running
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			CFG_ATTACK:  att_ms = d[DUR_W-1:0];
			CFG_DECAY:   dec_ms = d[DUR_W-1:0];
			CFG_SUSTAIN: sus_lvl = d;
			CFG_RELEASE: rel_ms = d[DUR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] d,
			input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] r);
		wait_idle();
		write_reg(CFG_ATTACK, a);
		write_reg(CFG_DECAY, d);
		write_reg(CFG_SUSTAIN, s);
		write_reg(CFG_RELEASE, r);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] rand_duration();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return CFG_W'($urandom_range(1, 60));
		else if (r < 85)
			return CFG_W'($urandom_range(61, 1000));
		else if (r < 90)
			return '0;
		return CFG_W'($urandom_range(0, 17'h1FFFF));
	endfunction

	function automatic logic [CFG_W-1:0] rand_sustain();
		case ($urandom_range(5))
			0: return '0;
			1: return FULL_SCALE;
			2: return CFG_W'($urandom_range(17'h10001, 17'h1FFFF));
			default: return CFG_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [EL_W-1:0] rand_elapsed();
		case ($urandom_range(3))
			0: return EL_W'($urandom_range(0, 255));
			3: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return EL_W'($urandom_range(0, 16));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_word(OP_TICK, 8'd0);
		send_word(OP_GATE_OFF, 8'd0);
		send_word(OP_TICK, 8'd255);
		send_word(OP_GATE_ON, 8'hFF);
		send_word(OP_TICK, 8'd0);
		send_word(OP_TICK, 8'd5);
		send_word(OP_TICK, 8'd5);
		send_word(OP_TICK, 8'd1);
		send_word(OP_TICK, 8'd50);
		send_word(OP_TICK, 8'd255);
		send_word(OP_TICK, 8'd7);
		// retrigger from sustain resumes attack part way
		send_word(OP_GATE_ON, 8'd0);
		send_word(OP_TICK, 8'd2);
		send_word(OP_GATE_OFF, 8'h55);
		send_word(OP_TICK, 8'd100);
		send_word(OP_TICK, 8'd255);
		send_word(OP_TICK, 8'd3);
		send_word(OP_UNUSED, 8'hAA);
		send_word(OP_TICK, 8'd1);
	endtask

	task automatic test_setting_extremes();
		set_config('0, '0, 17'h1FFFF, '0);
		send_word(OP_GATE_ON, 8'd0);
		send_word(OP_TICK, 8'd0);
		send_word(OP_TICK, 8'd1);
		send_word(OP_TICK, 8'd0);
		send_word(OP_TICK, 8'd1);
		send_word(OP_TICK, 8'd0);
		send_word(OP_GATE_OFF, 8'd0);
		send_word(OP_TICK, 8'd0);
		send_word(OP_TICK, 8'd1);
		set_config(17'hFFFF, 17'hFFFF, '0, 17'hFFFF);
		send_word(OP_GATE_ON, 8'd0);
		send_word(OP_TICK, 8'd255);
		send_word(OP_TICK, 8'd255);
		send_word(OP_GATE_ON, 8'd0);
		send_word(OP_TICK, 8'd255);
		send_word(OP_GATE_OFF, 8'd0);
		send_word(OP_TICK, 8'd255);
		send_word(OP_TICK, 8'd0);
	endtask

	task automatic run_random_notes(input int n);
		int sent;
		int ticks;
		int k;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 80) begin
				// note: gate on, some ticks, maybe a retrigger, gate off, up to 15 ticks until idle
				send_word(OP_GATE_ON, EL_W'($urandom));
				ticks = $urandom_range(1, 12);
				for (k = 0; k < ticks; k++) begin
					if ($urandom_range(9) == 0)
						send_word(OP_GATE_ON, EL_W'($urandom));
					send_word(OP_TICK, rand_elapsed());
				end
				send_word(OP_GATE_OFF, EL_W'($urandom));
				sent += ticks + 2;
				k = 0;
				while (env_phase != PH_IDLE && k < 15) begin
					send_word(OP_TICK, rand_elapsed());
					k++;
				end
				sent += k;
			end else begin
				ticks = $urandom_range(1, 4);
				for (k = 0; k < ticks; k++)
					send_word(OP_W'($urandom_range(3)), EL_W'($urandom));
				sent += ticks;
			end
		end
	endtask

	task automatic test_random_envelopes();
		int p;
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 70, 0, 27};
		stall_set = '{0, 0, 70, 27};
		for (p = 0; p < 4; p++) begin
			set_config(rand_duration(), rand_duration(), rand_sustain(), rand_duration());
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			run_random_notes(80);
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_long_stall();
		int k;
		set_config(17'd20, 17'd40, 17'd30000, 17'd50);
		stall_hold = 600;
		send_word(OP_GATE_ON, 8'd0);
		for (k = 0; k < 30; k++)
			send_word($urandom_range(7) == 0 ? OP_GATE_OFF : OP_TICK, rand_elapsed());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_setting_extremes();
		test_random_envelopes();
		test_long_stall();
		wait_idle();
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
